/* rtl/lpw_pkg.sv */
// Package for the line pixel walker: item and pixel types, widths, constants
// and the end point clamp. No dependencies.
`timescale 1ns / 1ps

package lpw_pkg;

    localparam int COORD_W    = 10;
    localparam int STRIDE_W   = 11;
    localparam int COLOR_W    = 16;
    localparam int OFFSET_W   = 21;
    localparam int POS_W      = COORD_W + 2;
    localparam int ERR_W      = COORD_W + 3;
    localparam int COORD_MAX  = 1023;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd320;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef logic [COORD_W-1:0]        t_coord;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [ERR_W-1:0]   t_err;

    typedef struct packed {
        t_op                op;
        t_coord             start_x;
        t_coord             start_y;
        t_coord             end_x;
        t_coord             end_y;
        logic [COLOR_W-1:0] draw_color;
        logic               restore_mode;
    } t_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] pixel_offset;
        logic [COLOR_W-1:0]  pixel_color;
        logic                from_background;
        logic                last_pixel;
    } t_pixel;

    function automatic t_coord coord_clamp(input t_coord v);
        logic [POS_W-1:0] wide;
        wide = {2'b00, v};
        if (wide > POS_W'(COORD_MAX)) begin
            return COORD_W'(COORD_MAX);
        end
        return v;
    endfunction

endpackage

/* rtl/lpw_in_reg.sv */
// Input register of the line pixel walker: holds one accepted item.
// Depends on lpw_pkg.
`timescale 1ns / 1ps

module lpw_in_reg import lpw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_retire,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_retire;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/lpw_core.sv */
// Walker state and the single-pass step: orders end points on start, emits
// the current pixel and moves one place. Depends on lpw_pkg.
`timescale 1ns / 1ps

module lpw_core import lpw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic                i_retire,
    input  logic [STRIDE_W-1:0] i_stride,
    output logic                o_emit,
    output t_pixel              o_pixel
);

    t_pos               r_wx, r_wy, r_lx, r_ly, r_sy;
    t_pos               r_sx;
    t_err               r_err;
    logic               r_down;
    logic [COLOR_W-1:0] r_color;
    logic               r_restore;
    logic               r_walking;

    t_coord             ax, ay, bx, by;
    logic               from_a, st_down, is_start;
    t_pos               st_wx, st_wy, st_lx, st_ly, st_sx, st_sy;
    t_err               st_err;

    t_pos               c_wx, c_wy, c_lx, c_ly, c_sx, c_sy;
    t_err               c_err;
    logic               c_down;
    logic [COLOR_W-1:0] c_color;
    logic               c_restore;

    t_pos               n_wx, n_wy;
    t_err               n_err;
    logic               more;
    logic [OFFSET_W-1:0] prod;

    assign is_start = (i_item.op == OP_START);
    assign ax = coord_clamp(i_item.start_x);
    assign ay = coord_clamp(i_item.start_y);
    assign bx = coord_clamp(i_item.end_x);
    assign by = coord_clamp(i_item.end_y);

    always_comb begin
        priority if (ax <= bx && ay <= by) begin
            from_a  = 1'b1;
            st_down = 1'b0;
        end else if (ax >= bx && ay >= by) begin
            from_a  = 1'b0;
            st_down = 1'b0;
        end else if (ax <= bx) begin
            from_a  = 1'b1;
            st_down = 1'b1;
        end else begin
            from_a  = 1'b0;
            st_down = 1'b1;
        end
        st_wx  = from_a ? t_pos'({2'b00, ax}) : t_pos'({2'b00, bx});
        st_wy  = from_a ? t_pos'({2'b00, ay}) : t_pos'({2'b00, by});
        st_lx  = from_a ? t_pos'({2'b00, bx}) : t_pos'({2'b00, ax});
        st_ly  = from_a ? t_pos'({2'b00, by}) : t_pos'({2'b00, ay});
        st_sx  = st_lx - st_wx;
        st_sy  = st_ly - st_wy;
        st_err = st_down ? -ERR_W'(st_sx) : ERR_W'(st_sx);
    end

    always_comb begin
        c_wx      = is_start ? st_wx : r_wx;
        c_wy      = is_start ? st_wy : r_wy;
        c_lx      = is_start ? st_lx : r_lx;
        c_ly      = is_start ? st_ly : r_ly;
        c_sx      = is_start ? st_sx : r_sx;
        c_sy      = is_start ? st_sy : r_sy;
        c_err     = is_start ? st_err : r_err;
        c_down    = is_start ? st_down : r_down;
        c_color   = is_start ? i_item.draw_color : r_color;
        c_restore = is_start ? i_item.restore_mode : r_restore;
    end

    always_comb begin
        n_wx  = c_wx;
        n_wy  = c_wy;
        if (!c_down) begin
            if (c_err < ERR_W'(c_sy)) begin
                n_err = c_err + ERR_W'(c_sx);
                n_wy  = c_wy + POS_W'(1);
            end else begin
                n_err = c_err - ERR_W'(c_sy);
                n_wx  = c_wx + POS_W'(1);
            end
            more = (n_wy <= c_ly) && (n_wx <= c_lx);
        end else begin
            if (c_err > ERR_W'(c_sy)) begin
                n_err = c_err - ERR_W'(c_sx);
                n_wy  = c_wy - POS_W'(1);
            end else begin
                n_err = c_err - ERR_W'(c_sy);
                n_wx  = c_wx + POS_W'(1);
            end
            more = (n_wy >= c_ly) && (n_wx <= c_lx);
        end
    end

    assign prod = OFFSET_W'(c_wy[COORD_W-1:0]) * OFFSET_W'(i_stride);
    assign o_emit = is_start || r_walking;
    assign o_pixel.pixel_offset    = OFFSET_W'({prod[OFFSET_W-2:0], 1'b0})
                                   + OFFSET_W'({c_wx[COORD_W-1:0], 1'b0});
    assign o_pixel.pixel_color     = c_restore ? '0 : c_color;
    assign o_pixel.from_background = c_restore;
    assign o_pixel.last_pixel      = !more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx      <= '0;
            r_wy      <= '0;
            r_lx      <= '0;
            r_ly      <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_err     <= '0;
            r_down    <= 1'b0;
            r_color   <= '0;
            r_restore <= 1'b0;
            r_walking <= 1'b0;
        end else if (i_retire && o_emit) begin
            r_wx      <= n_wx;
            r_wy      <= n_wy;
            r_lx      <= c_lx;
            r_ly      <= c_ly;
            r_sx      <= c_sx;
            r_sy      <= c_sy;
            r_err     <= n_err;
            r_down    <= c_down;
            r_color   <= c_color;
            r_restore <= c_restore;
            r_walking <= more;
        end
    end

endmodule

/* rtl/lpw_out_reg.sv */
// Result register of the line pixel walker: holds one pixel write until
// transferred. Depends on lpw_pkg.
`timescale 1ns / 1ps

module lpw_out_reg import lpw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_pixel i_pixel,
    input  logic   i_ready,
    output logic   o_free,
    output logic   o_valid,
    output t_pixel o_pixel
);

    logic   r_valid;
    t_pixel r_pixel;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pixel <= i_pixel;
        end
    end

endmodule

/* rtl/line_pixel_walker_top.sv */
// Top level of the four-connected line pixel walker: input register, walker
// core, result register and the stride register. Depends on lpw_pkg.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------
//  in      | in        | i_in_valid / o_in_ready      | op, end points, colour, mode
//  out     | out       | o_out_valid / i_out_ready    | offset, colour, flag, last
//  cfg     | in        | i_cfg_we                     | i_cfg_wdata (row stride)
//
// One item per cycle unless the output stalls; each pixel is registered.
// The walker step and the row offset multiply sit between the input and
// result registers. Synchronous active-low reset clears all control state
// and sets the stride to 320. A stalled output holds the result register;
// a step while idle retires without a result.
`timescale 1ns / 1ps

module line_pixel_walker_top import lpw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [COORD_W-1:0]  i_start_x,
    input  logic [COORD_W-1:0]  i_start_y,
    input  logic [COORD_W-1:0]  i_end_x,
    input  logic [COORD_W-1:0]  i_end_y,
    input  logic [COLOR_W-1:0]  i_draw_color,
    input  logic                i_restore_mode,
    input  logic                i_cfg_we,
    input  logic [STRIDE_W-1:0] i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OFFSET_W-1:0] o_pixel_offset,
    output logic [COLOR_W-1:0]  o_pixel_color,
    output logic                o_from_background,
    output logic                o_last_pixel
);

    logic [STRIDE_W-1:0] r_stride;
    t_item               in_item, held_item;
    logic                held_valid, retire, emit, out_free;
    t_pixel              core_pixel, out_pixel;

    assign in_item.op           = t_op'(i_op);
    assign in_item.start_x      = i_start_x;
    assign in_item.start_y      = i_start_y;
    assign in_item.end_x        = i_end_x;
    assign in_item.end_y        = i_end_y;
    assign in_item.draw_color   = i_draw_color;
    assign in_item.restore_mode = i_restore_mode;

    assign retire = held_valid && (out_free || !emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            r_stride <= i_cfg_wdata;
        end
    end

    lpw_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (in_item),
        .i_retire (retire),
        .o_valid  (held_valid),
        .o_item   (held_item)
    );

    lpw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (held_item),
        .i_retire (retire),
        .i_stride (r_stride),
        .o_emit   (emit),
        .o_pixel  (core_pixel)
    );

    lpw_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (retire && emit),
        .i_pixel (core_pixel),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_pixel (out_pixel)
    );

    assign o_pixel_offset    = out_pixel.pixel_offset;
    assign o_pixel_color     = out_pixel.pixel_color;
    assign o_from_background = out_pixel.from_background;
    assign o_last_pixel      = out_pixel.last_pixel;

endmodule

/* sim/line_pixel_walker_check.sv */
// Checker for the line pixel walker: watches the item, stride and pixel channels,
// predicts every pixel write and compares it field by field. Depends on lpw_pkg.
`timescale 1ns / 1ps

module line_pixel_walker_check import lpw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_item               i_item,
    input  logic                i_cfg_we,
    input  logic [STRIDE_W-1:0] i_cfg_wdata,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [OFFSET_W-1:0] i_pixel_offset,
    input  logic [COLOR_W-1:0]  i_pixel_color,
    input  logic                i_from_background,
    input  logic                i_last_pixel,
    output int                  o_fail_count,
    output int                  o_backlog
);

    t_pos                pos_x, pos_y, lim_x, lim_y, run_x, rise_y;
    t_err                err;
    logic                downward;
    logic                restore_held;
    logic                active;
    logic [COLOR_W-1:0]  color_held;
    logic [STRIDE_W-1:0] stride;
    t_pixel              pending_pixels[$];

    initial begin
        o_fail_count = 0;
        o_backlog    = 0;
    end

    function automatic t_pos widen(input t_coord c);
        t_coord v;
        v = (int'(c) > COORD_MAX) ? COORD_W'(COORD_MAX) : c;
        return t_pos'({2'b00, v});
    endfunction

    // emit the pixel at the current position, then move one place
    task automatic plot_and_move();
        t_pixel      px;
        int unsigned off;
        logic        more;
        off = 2 * int'(pos_x) + 2 * int'(pos_y) * int'(stride);
        px.pixel_offset    = off[OFFSET_W-1:0];
        px.pixel_color     = restore_held ? '0 : color_held;
        px.from_background = restore_held;
        if (!downward) begin
            if (err < rise_y) begin
                err   = err + run_x;
                pos_y = pos_y + 1;
            end else begin
                err   = err - rise_y;
                pos_x = pos_x + 1;
            end
            more = (pos_y <= lim_y) && (pos_x <= lim_x);
        end else begin
            if (err > rise_y) begin
                err   = err - run_x;
                pos_y = pos_y - 1;
            end else begin
                err   = err - rise_y;
                pos_x = pos_x + 1;
            end
            more = (pos_y >= lim_y) && (pos_x <= lim_x);
        end
        px.last_pixel = !more;
        active = more;
        pending_pixels.push_back(px);
    endtask

    task automatic walk_line_item(input t_item it);
        t_pos ax, ay, bx, by;
        logic from_a;
        if (it.op == OP_START) begin
            ax = widen(it.start_x);
            ay = widen(it.start_y);
            bx = widen(it.end_x);
            by = widen(it.end_y);
            if (ax <= bx && ay <= by) begin
                from_a   = 1'b1;
                downward = 1'b0;
            end else if (ax >= bx && ay >= by) begin
                from_a   = 1'b0;
                downward = 1'b0;
            end else if (ax <= bx) begin
                from_a   = 1'b1;
                downward = 1'b1;
            end else begin
                from_a   = 1'b0;
                downward = 1'b1;
            end
            if (from_a) begin
                pos_x = ax; pos_y = ay; lim_x = bx; lim_y = by;
            end else begin
                pos_x = bx; pos_y = by; lim_x = ax; lim_y = ay;
            end
            run_x        = lim_x - pos_x;
            rise_y       = lim_y - pos_y;
            err          = downward ? -run_x : run_x;
            color_held   = it.draw_color;
            restore_held = it.restore_mode;
            plot_and_move();
        end else if (active) begin
            plot_and_move();
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            pos_x = '0; pos_y = '0; lim_x = '0; lim_y = '0;
            run_x = '0; rise_y = '0; err = '0;
            downward     = 1'b0;
            restore_held = 1'b0;
            active       = 1'b0;
            color_held   = '0;
            stride       = STRIDE_RESET;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                stride = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel_offset: expected no transfer, got %0d", i_pixel_offset);
                    o_fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.pixel_offset !== i_pixel_offset) begin
                        $error("pixel_offset: expected %0d, got %0d",
                               want.pixel_offset, i_pixel_offset);
                        o_fail_count++;
                    end
                    if (want.pixel_color !== i_pixel_color) begin
                        $error("pixel_color: expected %h, got %h",
                               want.pixel_color, i_pixel_color);
                        o_fail_count++;
                    end
                    if (want.from_background !== i_from_background) begin
                        $error("from_background: expected %b, got %b",
                               want.from_background, i_from_background);
                        o_fail_count++;
                    end
                    if (want.last_pixel !== i_last_pixel) begin
                        $error("last_pixel: expected %b, got %b",
                               want.last_pixel, i_last_pixel);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                walk_line_item(i_item);
            end
        end
        o_backlog = pending_pixels.size();
    end

endmodule

/* sim/line_pixel_walker_top_test.sv */
// Testbench top for the line pixel walker: clock, reset, line and step stimulus,
// stride writes and output stalls. Depends on lpw_pkg and line_pixel_walker_check.
`timescale 1ns / 1ps

module line_pixel_walker_top_test;
    import lpw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 1050;
    localparam logic [STRIDE_W-1:0] STRIDE_PLAN [5] = '{11'd1, 11'd1024, 11'd2047, 11'd0,
                                                        11'd320};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_item               item_bus = '0;
    logic                cfg_we = 1'b0;
    logic [STRIDE_W-1:0] cfg_wdata = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [OFFSET_W-1:0] pix_offset;
    logic [COLOR_W-1:0]  pix_color;
    logic                pix_background;
    logic                pix_last;
    int                  fail_count;
    int                  backlog;
    int                  cycles = 0;
    int                  pixel_items = 0;
    int                  rx_wait = 0;
    logic                rx_took = 1'b0;
    logic                rx_calm = 1'b0;
    logic                tx_calm = 1'b0;

    always #5 clk = ~clk;

    line_pixel_walker_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_op             (item_bus.op),
        .i_start_x        (item_bus.start_x),
        .i_start_y        (item_bus.start_y),
        .i_end_x          (item_bus.end_x),
        .i_end_y          (item_bus.end_y),
        .i_draw_color     (item_bus.draw_color),
        .i_restore_mode   (item_bus.restore_mode),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_pixel_offset   (pix_offset),
        .o_pixel_color    (pix_color),
        .o_from_background(pix_background),
        .o_last_pixel     (pix_last)
    );

    line_pixel_walker_check u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_item           (item_bus),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_pixel_offset   (pix_offset),
        .i_pixel_color    (pix_color),
        .i_from_background(pix_background),
        .i_last_pixel     (pix_last),
        .o_fail_count     (fail_count),
        .o_backlog        (backlog)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stall the pixel side for a fresh random count after every transfer, none while calm
    always @(posedge clk) rx_took <= out_valid && out_ready;

    always @(negedge clk) begin
        if (rx_took) begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
        end
        if (rx_wait > 0) begin
            out_ready <= 1'b0;
            rx_wait--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_item step_item();
        t_item it;
        it.op           = OP_STEP;
        it.start_x      = t_coord'($urandom);
        it.start_y      = t_coord'($urandom);
        it.end_x        = t_coord'($urandom);
        it.end_y        = t_coord'($urandom);
        it.draw_color   = COLOR_W'($urandom);
        it.restore_mode = 1'($urandom);
        return it;
    endfunction

    function automatic int fit_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    task automatic send(input t_item it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [COLOR_W-1:0] color, input logic restore,
                             input int steps);
        t_item it;
        int    span;
        it.op           = OP_START;
        it.start_x      = t_coord'(sx);
        it.start_y      = t_coord'(sy);
        it.end_x        = t_coord'(ex);
        it.end_y        = t_coord'(ey);
        it.draw_color   = color;
        it.restore_mode = restore;
        span = ((ex > sx) ? ex - sx : sx - ex) + ((ey > sy) ? ey - sy : sy - ey);
        send(it);
        repeat (steps) send(step_item());
        pixel_items += 1 + ((steps < span) ? steps : span);
    endtask

    task automatic random_line();
        int sx, sy, ex, ey, reach, span, steps, pick;
        pick = $urandom_range(0, 9);
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        if (pick == 0) begin
            sx = $urandom_range(0, 1) * COORD_MAX;
            sy = $urandom_range(0, 1) * COORD_MAX;
        end
        reach = (pick == 1) ? 40 : 10;
        ex = fit_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
        ey = fit_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
        span = ((ex > sx) ? ex - sx : sx - ex) + ((ey > sy) ? ey - sy : sy - ey);
        steps = span;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            steps = span + $urandom_range(1, 3);
        end else if (pick == 1) begin
            steps = $urandom_range(0, span);
        end
        if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
        draw_line(sx, sy, ex, ey, COLOR_W'($urandom), ($urandom_range(0, 3) == 0), steps);
    endtask

    // hold off until every pixel is out and the pipeline has emptied
    task automatic settle();
        in_valid <= 1'b0;
        while (backlog != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_stride(input logic [STRIDE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int phase;
        int phase_end;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(step_item());
        draw_line(0, 0, 0, 0, 16'hFFFF, 1'b0, 1);
        draw_line(1023, 1023, 1020, 1023, 16'hAAAA, 1'b1, 3);
        draw_line(0, 3, 2, 0, 16'h5555, 1'b0, 5);
        draw_line(1023, 0, 1021, 2, 16'h0000, 1'b0, 4);
        draw_line(5, 5, 9, 9, 16'h1234, 1'b0, 2);
        draw_line(1023, 1023, 1023, 1022, 16'h0000, 1'b0, 1);

        phase = 0;
        while (pixel_items < TARGET_ITEMS) begin
            settle();
            set_stride((phase < 5) ? STRIDE_PLAN[phase] : STRIDE_W'($urandom_range(1, 1024)));
            phase_end = pixel_items + $urandom_range(100, 220);
            repeat ($urandom_range(0, 2)) send(step_item());
            while (pixel_items < phase_end) random_line();
            phase++;
        end

        settle();
        repeat (6) @(negedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
